// File: sv/sstrk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sstrk_pkg;

    // table entries
    localparam int SEG_SLOTS = 256;

    // request actions
    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_INIT   = 3'd1;
    localparam logic [2:0] ACT_OPEN   = 3'd2;
    localparam logic [2:0] ACT_CLOSE  = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;
    localparam logic [2:0] ACT_WRITE  = 3'd5;
    localparam logic [2:0] ACT_ALLOC  = 3'd6;

    // result status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_WRONG     = 3'd1;
    localparam logic [2:0] STS_UNDERFLOW = 3'd2;
    localparam logic [2:0] STS_GROW      = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;
    localparam logic [2:0] STS_RANGE     = 3'd5;

    // entry states
    localparam logic [1:0] SEG_EMPTY  = 2'd0;
    localparam logic [1:0] SEG_OPEN   = 2'd1;
    localparam logic [1:0] SEG_CLOSED = 2'd2;

    localparam logic        KIND_JOURNAL = 1'b0;
    localparam logic [31:0] SEQ_NULL     = 32'hFFFF_FFFF;

    // config register reset values
    localparam logic [31:0] CFG_BYTES_RST = 32'd67108864;
    localparam logic [8:0]  CFG_INUSE_RST = 9'd256;

    // occupancy bitmap: one word per group of entries
    localparam int BMP_W  = 16;
    localparam int BMP_SH = 4;

    typedef struct packed {
        logic accept;
        logic clr_start;
        logic clr_step;
        logic scan_rd;
        logic scan_next;
        logic take_hit;
        logic miss;
        logic load;
        logic exec;
        logic reply;
    } t_cmd;

    typedef struct packed {
        logic alloc_bad;
        logic hit;
        logic scan_end;
        logic clr_last;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/sstrk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sstrk_ctrl
    import sstrk_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [2:0] i_action,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd,
    output logic            busy
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CLR      = 6'b000010,
        S_SCAN_RD  = 6'b000100,
        S_SCAN_CHK = 6'b001000,
        S_LOAD     = 6'b010000,
        S_EXEC     = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_reply;   // low only for the pass after reset

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.clr_start) begin
                r_clr_reply <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_action == ACT_CLEAR) begin
                        o_cmd.clr_start = 1'b1;
                        n_state = S_CLR;
                    end else if (i_action == ACT_ALLOC && !i_sts.alloc_bad) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.reply = r_clr_reply;
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state = S_LOAD;
                end else if (i_sts.scan_end) begin
                    o_cmd.miss = 1'b1;
                    n_state = S_EXEC;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec  = 1'b1;
                o_cmd.reply = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_chk_follows_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> $past(r_state == S_SCAN_RD))
        else $error("scan check without a bitmap read");

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_EXEC))
        else $error("entry load not followed by execute");

    a_clear_enters_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start && i_action == ACT_CLEAR) |=> (r_state == S_CLR))
        else $error("clear request did not start the clearing pass");

    a_single_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.reply |=> !o_cmd.reply)
        else $error("two replies in a row");

endmodule

`default_nettype wire

// File: sv/sstrk_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sstrk_dp
    import sstrk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [31:0] i_segment_bytes,
    input  wire logic [8:0]  i_segments_in_use,
    input  wire logic [2:0]  i_action,
    input  wire logic [7:0]  i_segment_index,
    input  wire logic [31:0] i_sequence_number,
    input  wire logic        i_segment_kind,
    input  wire logic [31:0] i_write_offset,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [7:0]       o_chosen_segment,
    output logic [8:0]       o_empty_count,
    output logic [8:0]       o_open_count,
    output logic [8:0]       o_closed_count,
    output logic [8:0]       o_journal_count,
    output logic [31:0]      o_opens_done,
    output logic [31:0]      o_releases_done,
    output logic [31:0]      o_closes_done,
    output logic [39:0]      o_free_bytes
);

    localparam int AW   = $clog2(SEG_SLOTS);
    localparam int ROWS = (SEG_SLOTS + BMP_W - 1) / BMP_W;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BW   = RW + BMP_SH;
    localparam int CW   = ((BW > 9) ? BW : 9) + 1;
    localparam logic [8:0]  LIVE_CAP = 9'((SEG_SLOTS > 511) ? 511 : SEG_SLOTS);
    localparam int          RST_LIVE_I = (SEG_SLOTS < int'(CFG_INUSE_RST)) ?
                                         SEG_SLOTS : int'(CFG_INUSE_RST);
    localparam logic [8:0]  RST_LIVE  = 9'(RST_LIVE_I);
    localparam logic [39:0] RST_AVAIL = 40'(64'(RST_LIVE_I) * 64'(CFG_BYTES_RST));
    localparam logic [AW-1:0] LAST_ENTRY = AW'(SEG_SLOTS - 1);
    localparam logic [AW:0]   ROWS_A     = (AW + 1)'(ROWS);

    typedef struct packed {
        logic [1:0]  st;
        logic        kind;
        logic [31:0] free;
    } t_entry;

    t_entry      m_ent [SEG_SLOTS];
    logic [BMP_W-1:0] m_bmp [ROWS];

    logic [2:0]  r_act;
    logic [7:0]  r_idx;
    logic [31:0] r_seq;
    logic        r_kind;
    logic [31:0] r_off;
    logic [AW-1:0] r_addr;
    logic [RW-1:0] r_row;
    logic        r_none;
    t_entry      r_ent;
    logic [BMP_W-1:0] r_word;
    logic [8:0]  r_ce, r_co, r_cc, r_cj;
    logic [31:0] r_ops_open, r_ops_rel, r_ops_close;
    logic [39:0] r_avail;
    logic [AW-1:0] r_clr_cnt;
    logic        r_done;
    logic [2:0]  r_status;
    logic [7:0]  r_chosen;

    logic [8:0]  live;
    logic [40:0] clr_prod;
    logic [AW-1:0] in_addr;

    always_comb begin
        live     = (i_segments_in_use > LIVE_CAP) ? LIVE_CAP : i_segments_in_use;
        clr_prod = 41'(live) * 41'(i_segment_bytes);
        in_addr  = AW'(i_segment_index);
    end

    // ---- allocate scan over the occupancy bitmap ----
    logic [CW-1:0]     base;
    logic [BMP_W-1:0]  cand;
    logic [BMP_SH-1:0] pe;
    logic [BW-1:0]     found;

    always_comb begin
        base = CW'({r_row, {BMP_SH{1'b0}}});
        for (int j = 0; j < BMP_W; j++) begin
            cand[j] = !r_word[j] && ((base + CW'(j)) < CW'(live));
        end
        pe = '0;
        for (int j = BMP_W - 1; j >= 0; j--) begin
            if (cand[j]) begin
                pe = BMP_SH'(j);
            end
        end
        found = {r_row, pe};
    end

    assign o_sts.alloc_bad = (i_sequence_number == SEQ_NULL) || (i_segment_bytes == 32'd0);
    assign o_sts.hit       = |cand;
    assign o_sts.scan_end  = (base + CW'(BMP_W)) >= CW'(live);
    assign o_sts.clr_last  = (r_clr_cnt == LAST_ENTRY);

    // ---- execute step ----
    logic        seq_bad, oob;
    logic [31:0] new_free, take;
    logic [40:0] rel_sum;
    logic [2:0]  n_status;
    logic [7:0]  n_chosen;
    logic        wr_ent, wr_bmp, bmp_val;
    t_entry      n_ent;
    logic [8:0]  n_ce, n_co, n_cc, n_cj;
    logic [31:0] n_ops_open, n_ops_rel, n_ops_close;
    logic [39:0] n_avail;
    logic [BMP_W-1:0] n_word;
    logic [BMP_SH-1:0] bpos;
    logic [RW-1:0] wr_row;

    always_comb begin
        seq_bad  = (r_seq == SEQ_NULL);
        oob      = (r_act >= ACT_INIT) && (r_act <= ACT_WRITE) && ({1'b0, r_idx} >= live);
        new_free = i_segment_bytes - r_off;
        take     = r_ent.free - new_free;
        rel_sum  = {1'b0, r_avail} + 41'(i_segment_bytes);
        bpos     = BMP_SH'(r_addr);
        wr_row   = RW'(r_addr >> BMP_SH);

        n_status    = STS_OK;
        n_chosen    = r_idx;
        wr_ent      = 1'b0;
        wr_bmp      = 1'b0;
        bmp_val     = 1'b0;
        n_ent       = r_ent;
        n_ce        = r_ce;
        n_co        = r_co;
        n_cc        = r_cc;
        n_cj        = r_cj;
        n_ops_open  = r_ops_open;
        n_ops_rel   = r_ops_rel;
        n_ops_close = r_ops_close;
        n_avail     = r_avail;

        if (oob) begin
            n_status = STS_RANGE;
        end else begin
            case (r_act)
                ACT_INIT: begin
                    if (seq_bad) n_status = STS_RANGE;
                    else if (r_ent.st != SEG_EMPTY) n_status = STS_WRONG;
                    else if (r_ce == 9'd0 || r_avail < 40'(i_segment_bytes))
                        n_status = STS_UNDERFLOW;
                    else begin
                        wr_ent  = 1'b1;
                        wr_bmp  = 1'b1;
                        bmp_val = 1'b1;
                        n_ent   = '{st: SEG_CLOSED, kind: r_kind, free: 32'd0};
                        n_ce    = r_ce - 9'd1;
                        n_cc    = r_cc + 9'd1;
                        if (r_kind == KIND_JOURNAL) n_cj = r_cj + 9'd1;
                        n_avail = r_avail - 40'(i_segment_bytes);
                    end
                end
                ACT_OPEN, ACT_ALLOC: begin
                    if (seq_bad || i_segment_bytes == 32'd0) n_status = STS_RANGE;
                    else if (r_act == ACT_ALLOC && r_none) n_status = STS_FULL;
                    else if (r_ent.st != SEG_EMPTY) n_status = STS_WRONG;
                    else if (r_ce == 9'd0) n_status = STS_UNDERFLOW;
                    else begin
                        wr_ent     = 1'b1;
                        wr_bmp     = 1'b1;
                        bmp_val    = 1'b1;
                        n_ent      = '{st: SEG_OPEN, kind: r_kind, free: i_segment_bytes};
                        n_ce       = r_ce - 9'd1;
                        n_co       = r_co + 9'd1;
                        if (r_kind == KIND_JOURNAL) n_cj = r_cj + 9'd1;
                        n_ops_open = r_ops_open + 32'd1;
                    end
                    if (r_act == ACT_ALLOC) begin
                        n_chosen = (n_status == STS_OK) ? 8'(r_addr) : 8'd0;
                    end
                end
                ACT_CLOSE: begin
                    if (r_ent.st != SEG_OPEN) n_status = STS_WRONG;
                    else if (r_co == 9'd0 || r_avail < 40'(r_ent.free))
                        n_status = STS_UNDERFLOW;
                    else begin
                        wr_ent      = 1'b1;
                        n_ent.st    = SEG_CLOSED;
                        n_co        = r_co - 9'd1;
                        n_cc        = r_cc + 9'd1;
                        n_avail     = r_avail - 40'(r_ent.free);
                        n_ops_close = r_ops_close + 32'd1;
                    end
                end
                ACT_RELEASE: begin
                    if (r_ent.st != SEG_CLOSED) n_status = STS_WRONG;
                    else if (r_cc == 9'd0 ||
                             (r_ent.kind == KIND_JOURNAL && r_cj == 9'd0))
                        n_status = STS_UNDERFLOW;
                    else begin
                        wr_ent    = 1'b1;
                        wr_bmp    = 1'b1;
                        n_ent     = '{st: SEG_EMPTY, kind: 1'b0, free: 32'd0};
                        if (r_ent.kind == KIND_JOURNAL) n_cj = r_cj - 9'd1;
                        n_cc      = r_cc - 9'd1;
                        n_ce      = r_ce + 9'd1;
                        n_avail   = rel_sum[40] ? '1 : rel_sum[39:0];
                        n_ops_rel = r_ops_rel + 32'd1;
                    end
                end
                ACT_WRITE: begin
                    if (r_ent.st != SEG_OPEN) n_status = STS_WRONG;
                    else if (r_off > i_segment_bytes) n_status = STS_RANGE;
                    else if (r_ent.free < new_free) n_status = STS_GROW;
                    else if (r_avail < 40'(take)) n_status = STS_UNDERFLOW;
                    else begin
                        wr_ent     = 1'b1;
                        n_ent.free = new_free;
                        n_avail    = r_avail - 40'(take);
                    end
                end
                default: begin
                    n_status = STS_RANGE;
                end
            endcase
        end

        n_word       = r_word;
        n_word[bpos] = bmp_val;
    end

    // ---- memories ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_ent[r_clr_cnt] <= '{st: SEG_EMPTY, kind: 1'b0, free: 32'd0};
        end else if (i_cmd.exec && wr_ent) begin
            m_ent[r_addr] <= n_ent;
        end
        if (i_cmd.accept) begin
            r_ent <= m_ent[in_addr];
        end else if (i_cmd.load) begin
            r_ent <= m_ent[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && ({1'b0, r_clr_cnt} < ROWS_A)) begin
            m_bmp[RW'(r_clr_cnt)] <= '0;
        end else if (i_cmd.exec && wr_bmp) begin
            m_bmp[wr_row] <= n_word;
        end
        if (i_cmd.accept) begin
            r_word <= m_bmp[RW'(in_addr >> BMP_SH)];
        end else if (i_cmd.scan_rd) begin
            r_word <= m_bmp[r_row];
        end else if (i_cmd.load) begin
            r_word <= m_bmp[wr_row];
        end
    end

    // ---- request latch and scan control ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act  <= i_action;
            r_idx  <= i_segment_index;
            r_seq  <= i_sequence_number;
            r_kind <= i_segment_kind;
            r_off  <= i_write_offset;
            r_addr <= in_addr;
        end else if (i_cmd.take_hit) begin
            r_addr <= AW'(found);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_none    <= 1'b0;
            r_clr_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.reply;
            if (i_cmd.accept) begin
                r_row  <= '0;
                r_none <= 1'b0;
            end else if (i_cmd.scan_next) begin
                r_row <= r_row + RW'(1);
            end
            if (i_cmd.miss) begin
                r_none <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= o_sts.clr_last ? '0 : r_clr_cnt + AW'(1);
            end
        end
    end

    // ---- counters and result registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ce        <= RST_LIVE;
            r_co        <= '0;
            r_cc        <= '0;
            r_cj        <= '0;
            r_ops_open  <= '0;
            r_ops_rel   <= '0;
            r_ops_close <= '0;
            r_avail     <= RST_AVAIL;
        end else if (i_cmd.clr_start) begin
            r_ce        <= live;
            r_co        <= '0;
            r_cc        <= '0;
            r_cj        <= '0;
            r_ops_open  <= '0;
            r_ops_rel   <= '0;
            r_ops_close <= '0;
            r_avail     <= clr_prod[39:0];
        end else if (i_cmd.exec) begin
            r_ce        <= n_ce;
            r_co        <= n_co;
            r_cc        <= n_cc;
            r_cj        <= n_cj;
            r_ops_open  <= n_ops_open;
            r_ops_rel   <= n_ops_rel;
            r_ops_close <= n_ops_close;
            r_avail     <= n_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_start) begin
            r_status <= STS_OK;
            r_chosen <= i_segment_index;
        end else if (i_cmd.exec) begin
            r_status <= n_status;
            r_chosen <= n_chosen;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_chosen_segment = r_chosen;
    assign o_empty_count    = r_ce;
    assign o_open_count     = r_co;
    assign o_closed_count   = r_cc;
    assign o_journal_count  = r_cj;
    assign o_opens_done     = r_ops_open;
    assign o_releases_done  = r_ops_rel;
    assign o_closes_done    = r_ops_close;
    assign o_free_bytes     = r_avail;

    a_ok_keeps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status == STS_OK && r_act != ACT_ALLOC) |-> !oob)
        else $error("out-of-range index accepted");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |-> (CW'(found) < CW'(live)))
        else $error("allocate picked an entry beyond the live range");

endmodule

`default_nettype wire

// File: sv/segment_state_space_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Segment state and space tracker.
// Request channel: a request (action, segment index, sequence, kind, write
// offset) is taken at a clock edge where start is high and busy is low.
// Result channel: o_done is high for exactly one cycle while status, chosen
// segment, the four segment counts, the three operation counts and the free
// byte total sit on the result ports. Counts always show the state after
// the most recent request. The receiver cannot stall; each result is taken
// in its strobe cycle, and a new request may be taken in that same cycle.
// Plain requests go from the accepting edge to the execute state, which sets the
// result registers; busy stays high meanwhile, so a new request is not taken
// before the result. Allocate first reads and checks one occupancy bitmap word
// per group of 16 entries it searches, then loads the chosen entry. Clear
// walks the table, one entry a cycle, then gives its result.
// Reset (synchronous, active low) loads the config registers and counts and
// then runs the same clearing pass with busy high and no result; config
// writes over the APB port are taken at any time.
// Config: segment_bytes at byte address 0, segments_in_use at address 4.

module segment_state_space_tracker
    import sstrk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [7:0]  i_segment_index,
    input  wire logic [31:0] i_sequence_number,
    input  wire logic        i_segment_kind,
    input  wire logic [31:0] i_write_offset,
    // result
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [7:0]       o_chosen_segment,
    output logic [8:0]       o_empty_count,
    output logic [8:0]       o_open_count,
    output logic [8:0]       o_closed_count,
    output logic [8:0]       o_journal_count,
    output logic [31:0]      o_opens_done,
    output logic [31:0]      o_releases_done,
    output logic [31:0]      o_closes_done,
    output logic [39:0]      o_free_bytes
);

    logic [31:0] r_segment_bytes;
    logic [8:0]  r_segments_in_use;
    logic        cfg_wr;
    t_cmd        cmd;
    t_sts        sts;

    // registers decode on address bit 2 only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {23'd0, r_segments_in_use} : r_segment_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_bytes   <= CFG_BYTES_RST;
            r_segments_in_use <= CFG_INUSE_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_segments_in_use <= pwdata[8:0];
            end else begin
                r_segment_bytes <= pwdata;
            end
        end
    end

    sstrk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    sstrk_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_segment_bytes   (r_segment_bytes),
        .i_segments_in_use (r_segments_in_use),
        .i_action          (i_action),
        .i_segment_index   (i_segment_index),
        .i_sequence_number (i_sequence_number),
        .i_segment_kind    (i_segment_kind),
        .i_write_offset    (i_write_offset),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_chosen_segment  (o_chosen_segment),
        .o_empty_count     (o_empty_count),
        .o_open_count      (o_open_count),
        .o_closed_count    (o_closed_count),
        .o_journal_count   (o_journal_count),
        .o_opens_done      (o_opens_done),
        .o_releases_done   (o_releases_done),
        .o_closes_done     (o_closes_done),
        .o_free_bytes      (o_free_bytes)
    );

endmodule

`default_nettype wire

// File: verif/segment_tracker_checker.sv
`timescale 1ns / 1ps

// Watches the request, config and result channels and predicts every result.
module segment_tracker_checker
    import sstrk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [7:0]  i_segment_index,
    input  wire logic [31:0] i_sequence_number,
    input  wire logic        i_segment_kind,
    input  wire logic [31:0] i_write_offset,
    input  wire logic        i_done,
    input  wire logic [2:0]  i_status,
    input  wire logic [7:0]  i_chosen_segment,
    input  wire logic [8:0]  i_empty_count,
    input  wire logic [8:0]  i_open_count,
    input  wire logic [8:0]  i_closed_count,
    input  wire logic [8:0]  i_journal_count,
    input  wire logic [31:0] i_opens_done,
    input  wire logic [31:0] i_releases_done,
    input  wire logic [31:0] i_closes_done,
    input  wire logic [39:0] i_free_bytes,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  chosen;
        logic [8:0]  n_empty;
        logic [8:0]  n_open;
        logic [8:0]  n_closed;
        logic [8:0]  n_journal;
        logic [31:0] opens;
        logic [31:0] releases;
        logic [31:0] closes;
        logic [39:0] free_total;
    } tracker_result_t;

    localparam logic [39:0] FREE_MAX = 40'hFF_FFFF_FFFF;

    logic [31:0] seg_bytes;
    logic [8:0]  in_use;
    logic [1:0]  seg_state [256];
    logic [31:0] seg_seq   [256];
    logic        seg_kind  [256];
    logic [31:0] seg_free  [256];
    logic [8:0]  n_empty, n_open, n_closed, n_journal;
    logic [31:0] opens, releases, closes;
    logic [40:0] avail;

    tracker_result_t result_fifo [$];
    int mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = result_fifo.size();

    function automatic logic [8:0] live_count();
        return (in_use > 9'd256) ? 9'd256 : in_use;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < 256; i++) begin
            seg_state[i] = SEG_EMPTY;
            seg_seq[i]   = SEQ_NULL;
            seg_kind[i]  = 1'b0;
            seg_free[i]  = '0;
        end
        n_empty   = live_count();
        n_open    = '0;
        n_closed  = '0;
        n_journal = '0;
        opens     = '0;
        releases  = '0;
        closes    = '0;
        avail     = {1'b0, 40'(64'(live_count()) * 64'(seg_bytes))};
    endfunction

    function automatic logic [2:0] open_slot(int idx, logic [31:0] sq, logic k);
        if (seg_state[idx] != SEG_EMPTY) return STS_WRONG;
        if (n_empty == 0) return STS_UNDERFLOW;
        seg_state[idx] = SEG_OPEN;
        seg_seq[idx]   = sq;
        seg_kind[idx]  = k;
        seg_free[idx]  = seg_bytes;
        n_empty--;
        n_open++;
        if (k == KIND_JOURNAL) n_journal++;
        opens++;
        return STS_OK;
    endfunction

    function automatic tracker_result_t apply_request(logic [2:0] act, logic [7:0] idx,
                                                      logic [31:0] sq, logic k,
                                                      logic [31:0] off);
        tracker_result_t r;
        logic [2:0]  sts;
        logic [7:0]  pick;
        logic [31:0] new_free, take;
        logic [8:0]  n;
        int          hit;
        sts  = STS_OK;
        pick = idx;
        n    = live_count();
        hit  = -1;
        if (act == ACT_CLEAR) begin
            wipe_table();
        end else if (act >= ACT_INIT && act <= ACT_WRITE && {1'b0, idx} >= n) begin
            sts = STS_RANGE;
        end else if (act == ACT_INIT) begin
            if (sq == SEQ_NULL) sts = STS_RANGE;
            else if (seg_state[idx] != SEG_EMPTY) sts = STS_WRONG;
            else if (n_empty == 0 || avail < {9'd0, seg_bytes}) sts = STS_UNDERFLOW;
            else begin
                seg_state[idx] = SEG_CLOSED;
                seg_seq[idx]   = sq;
                seg_kind[idx]  = k;
                seg_free[idx]  = '0;
                n_empty--;
                n_closed++;
                if (k == KIND_JOURNAL) n_journal++;
                avail = avail - {9'd0, seg_bytes};
            end
        end else if (act == ACT_OPEN) begin
            if (sq == SEQ_NULL || seg_bytes == 0) sts = STS_RANGE;
            else sts = open_slot(idx, sq, k);
        end else if (act == ACT_CLOSE) begin
            if (seg_state[idx] != SEG_OPEN) sts = STS_WRONG;
            else if (n_open == 0 || avail < {9'd0, seg_free[idx]}) sts = STS_UNDERFLOW;
            else begin
                seg_state[idx] = SEG_CLOSED;
                n_open--;
                n_closed++;
                avail = avail - {9'd0, seg_free[idx]};
                closes++;
            end
        end else if (act == ACT_RELEASE) begin
            if (seg_state[idx] != SEG_CLOSED) sts = STS_WRONG;
            else if (n_closed == 0 || (seg_kind[idx] == KIND_JOURNAL && n_journal == 0))
                sts = STS_UNDERFLOW;
            else begin
                if (seg_kind[idx] == KIND_JOURNAL) n_journal--;
                seg_state[idx] = SEG_EMPTY;
                seg_seq[idx]   = SEQ_NULL;
                seg_kind[idx]  = 1'b0;
                seg_free[idx]  = '0;
                n_closed--;
                n_empty++;
                avail = avail + {9'd0, seg_bytes};
                if (avail > {1'b0, FREE_MAX}) avail = {1'b0, FREE_MAX};
                releases++;
            end
        end else if (act == ACT_WRITE) begin
            if (seg_state[idx] != SEG_OPEN) sts = STS_WRONG;
            else if (off > seg_bytes) sts = STS_RANGE;
            else begin
                new_free = seg_bytes - off;
                if (seg_free[idx] < new_free) sts = STS_GROW;
                else begin
                    take = seg_free[idx] - new_free;
                    if (avail < {9'd0, take}) sts = STS_UNDERFLOW;
                    else begin
                        avail = avail - {9'd0, take};
                        seg_free[idx] = new_free;
                    end
                end
            end
        end else if (act == ACT_ALLOC) begin
            pick = '0;
            if (sq == SEQ_NULL || seg_bytes == 0) sts = STS_RANGE;
            else begin
                for (int i = 0; i < 256; i++) begin
                    if (hit < 0 && i < n && seg_state[i] == SEG_EMPTY) hit = i;
                end
                if (hit < 0) sts = STS_FULL;
                else begin
                    sts = open_slot(hit, sq, k);
                    if (sts == STS_OK) pick = 8'(hit);
                end
            end
        end else begin
            sts = STS_RANGE;
        end
        r.status     = sts;
        r.chosen     = pick;
        r.n_empty    = n_empty;
        r.n_open     = n_open;
        r.n_closed   = n_closed;
        r.n_journal  = n_journal;
        r.opens      = opens;
        r.releases   = releases;
        r.closes     = closes;
        r.free_total = avail[39:0];
        return r;
    endfunction

    initial mismatches = 0;

    always @(posedge i_clk) begin
        tracker_result_t got;
        tracker_result_t want;
        got = {i_status, i_chosen_segment, i_empty_count, i_open_count, i_closed_count,
               i_journal_count, i_opens_done, i_releases_done, i_closes_done, i_free_bytes};
        if (!i_rst_n) begin
            seg_bytes = CFG_BYTES_RST;
            in_use    = CFG_INUSE_RST;
            wipe_table();
            result_fifo.delete();
        end else begin
            // results leave before the same-edge request is predicted
            if (i_done) begin
                if (result_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                end else begin
                    want = result_fifo.pop_front();
                    if (got.status !== want.status || got.chosen !== want.chosen ||
                        got.n_empty !== want.n_empty || got.n_open !== want.n_open ||
                        got.n_closed !== want.n_closed || got.n_journal !== want.n_journal ||
                        got.opens !== want.opens || got.releases !== want.releases ||
                        got.closes !== want.closes || got.free_total !== want.free_total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch\n  exp %p\n  got %p", $realtime, want, got);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == 3'd0) seg_bytes = i_pwdata;
                else if (i_paddr == 3'd4) in_use = i_pwdata[8:0];
            end
            if (i_start && !i_busy)
                result_fifo.push_back(apply_request(i_action, i_segment_index,
                                                    i_sequence_number, i_segment_kind,
                                                    i_write_offset));
        end
    end

endmodule

// File: verif/tb_segment_state_space_tracker.sv
`timescale 1ns / 1ps

// Stimulus and verdict; all prediction lives in the checker.
module tb_segment_state_space_tracker;
    import sstrk_pkg::*;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        start, busy;
    logic [2:0]  i_action;
    logic [7:0]  i_segment_index;
    logic [31:0] i_sequence_number;
    logic        i_segment_kind;
    logic [31:0] i_write_offset;
    logic        o_done;
    logic [2:0]  o_status;
    logic [7:0]  o_chosen_segment;
    logic [8:0]  o_empty_count, o_open_count, o_closed_count, o_journal_count;
    logic [31:0] o_opens_done, o_releases_done, o_closes_done;
    logic [39:0] o_free_bytes;
    int          fail_count, pending;

    // current config, mirrored here only to shape stimulus
    logic [31:0] cur_bytes;
    logic [8:0]  cur_in_use;

    segment_state_space_tracker u_top (.*);

    segment_tracker_checker u_chk (
        .i_clk, .i_rst_n,
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .i_start(start), .i_busy(busy),
        .i_action, .i_segment_index, .i_sequence_number, .i_segment_kind,
        .i_write_offset,
        .i_done(o_done), .i_status(o_status), .i_chosen_segment(o_chosen_segment),
        .i_empty_count(o_empty_count), .i_open_count(o_open_count),
        .i_closed_count(o_closed_count), .i_journal_count(o_journal_count),
        .i_opens_done(o_opens_done), .i_releases_done(o_releases_done),
        .i_closes_done(o_closes_done), .i_free_bytes(o_free_bytes),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #50ms;
        $display("segment_state_space_tracker test failed");
        $finish;
    end

    // APB write: setup cycle, then access cycle; pready is tied high
    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == 3'd0) cur_bytes = data;
        else cur_in_use = data[8:0];
    endtask

    // block must be quiet before config changes; every request yields a result
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_config(logic [31:0] bytes, logic [8:0] segs);
        drain();
        cfg_write(3'd0, bytes);
        cfg_write(3'd4, {23'd0, segs});
    endtask

    // raise start with the request and hold until an edge with busy low;
    // start stays high afterward, the caller lowers it on a gap
    task automatic issue(logic [2:0] act, logic [7:0] idx, logic [31:0] sq,
                         logic k, logic [31:0] off);
        start             = 1'b1;
        i_action          = act;
        i_segment_index   = idx;
        i_sequence_number = sq;
        i_segment_kind    = k;
        i_write_offset    = off;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            start = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // random request, mostly well formed for the current table size
    task automatic random_request();
        logic [2:0]  act;
        logic [7:0]  idx;
        logic [31:0] sq, off;
        int          live, pick;
        live = (cur_in_use > 9'd256) ? 256 : int'(cur_in_use);
        if (live == 0) live = 1;
        pick = $urandom_range(99);
        if (pick < 1) act = ACT_CLEAR;
        else if (pick < 2) act = 3'd7;
        else if (pick < 12) act = ACT_INIT;
        else if (pick < 27) act = ACT_OPEN;
        else if (pick < 42) act = ACT_CLOSE;
        else if (pick < 57) act = ACT_RELEASE;
        else if (pick < 80) act = ACT_WRITE;
        else act = ACT_ALLOC;
        idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(live - 1));
        sq  = ($urandom_range(19) == 0) ? SEQ_NULL : $urandom;
        // offsets: mostly inside the segment and near its end, some beyond
        case ($urandom_range(3))
            0: off = $urandom;
            1: off = $urandom_range(cur_bytes);
            default: off = (cur_bytes >= 32'd64) ?
                cur_bytes - $urandom_range(63) : $urandom_range(cur_bytes);
        endcase
        issue(act, idx, sq, 1'($urandom), off);
    endtask

    initial begin
        // settings visited by the random part; extremes included
        logic [31:0] bytes_set [7] = '{32'd4096, 32'd1, 32'hFFFF_FFFF, 32'd0,
                                       32'd67108864, 32'd100, 32'h8000_0000};
        logic [8:0]  segs_set  [7] = '{9'd8, 9'd1, 9'd256, 9'd2, 9'd511, 9'd17, 9'd40};
        int burst_mode;

        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0;
        i_action = ACT_CLEAR; i_segment_index = '0; i_sequence_number = '0;
        i_segment_kind = 1'b0; i_write_offset = '0;
        cur_bytes  = CFG_BYTES_RST;
        cur_in_use = CFG_INUSE_RST;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every action, range and state errors, field extremes
        issue(ACT_ALLOC, 8'd0, 32'd0, KIND_JOURNAL, '0);
        issue(ACT_OPEN, 8'd255, 32'hFFFF_FFFE, 1'b1, '0);
        issue(ACT_OPEN, 8'd255, 32'd5, 1'b0, '0);            // already open
        issue(ACT_WRITE, 8'd255, 32'd0, 1'b0, 32'd1024);
        issue(ACT_WRITE, 8'd255, 32'd0, 1'b0, 32'd10);       // free space grows
        issue(ACT_WRITE, 8'd255, 32'd0, 1'b0, 32'hFFFF_FFFF); // past segment end
        issue(ACT_WRITE, 8'd255, 32'd0, 1'b0, CFG_BYTES_RST);
        issue(ACT_CLOSE, 8'd255, 32'd0, 1'b0, '0);
        issue(ACT_CLOSE, 8'd255, 32'd0, 1'b0, '0);           // not open
        issue(ACT_RELEASE, 8'd255, 32'd0, 1'b0, '0);
        issue(ACT_RELEASE, 8'd3, 32'd0, 1'b0, '0);           // not closed
        issue(ACT_INIT, 8'd7, 32'd9, KIND_JOURNAL, '0);
        issue(ACT_INIT, 8'd8, SEQ_NULL, 1'b0, '0);           // null sequence
        issue(ACT_ALLOC, 8'd0, SEQ_NULL, 1'b0, '0);
        issue(3'd7, 8'hAA, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
        issue(ACT_CLEAR, 8'd0, 32'd0, 1'b0, '0);
        set_config(32'd0, 9'd2);
        issue(ACT_OPEN, 8'd1, 32'd1, 1'b0, '0);              // zero segment size
        issue(ACT_ALLOC, 8'd0, 32'd1, 1'b0, '0);
        issue(ACT_INIT, 8'd2, 32'd1, 1'b0, '0);              // index past table
        issue(ACT_CLEAR, 8'd0, 32'd0, 1'b0, '0);
        set_config(32'd16, 9'd1);
        issue(ACT_ALLOC, 8'd0, 32'd3, 1'b1, '0);
        issue(ACT_ALLOC, 8'd0, 32'd4, 1'b1, '0);             // table full
        idle_gap(1);

        // random part: a new setting every 200 requests, without clearing,
        // so state built under one setting meets the next one
        burst_mode = 0;
        for (int n = 0; n < 1500; n++) begin
            if (n % 200 == 0) begin
                start = 1'b0;
                if (n / 200 < 7) set_config(bytes_set[n / 200], segs_set[n / 200]);
                else set_config($urandom, 9'($urandom_range(256, 1)));
            end
            if (n % 50 == 0) burst_mode = $urandom_range(2);
            // sender holds off once until the block has drained
            if (n == 777) begin
                start = 1'b0;
                drain();
            end
            random_request();
            if (burst_mode != 0) idle_gap($urandom_range(15));
        end
        start = 1'b0;

        drain();
        repeat (300) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("segment_state_space_tracker test passed");
        end else begin
            $display("segment_state_space_tracker test failed");
        end
        $finish;
    end

endmodule
